### design/hab_pkg.sv
package hab_pkg;

  localparam int TempWidth  = 17;
  localparam int CountWidth = 16;
  localparam int ColorWidth = 24;
  localparam int CmdWidth   = 2;
  localparam int RegIdxWidth = 3;
  localparam int CfgDataWidth = 24;

  // command codes
  localparam logic [CmdWidth-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_TICK   = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_TEST   = 2'd2;

  // register indexes
  localparam logic [RegIdxWidth-1:0] REG_ALARM_ENABLE   = 3'd0;
  localparam logic [RegIdxWidth-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [RegIdxWidth-1:0] REG_LOW_THRESHOLD  = 3'd2;
  localparam logic [RegIdxWidth-1:0] REG_HYSTERESIS     = 3'd3;
  localparam logic [RegIdxWidth-1:0] REG_BLINK_PERIOD   = 3'd4;
  localparam logic [RegIdxWidth-1:0] REG_TONE_FREQUENCY = 3'd5;
  localparam logic [RegIdxWidth-1:0] REG_ALARM_COLOR    = 3'd6;
  localparam logic [RegIdxWidth-1:0] REG_OUTPUT_FLAGS   = 3'd7;

  // register reset values
  localparam logic                    RST_ALARM_ENABLE   = 1'b0;
  localparam logic [TempWidth-1:0]    RST_HIGH_THRESHOLD = 17'd6400;
  localparam logic [TempWidth-1:0]    RST_LOW_THRESHOLD  = 17'd0;
  localparam logic [CountWidth-1:0]   RST_HYSTERESIS     = 16'd128;
  localparam logic [CountWidth-1:0]   RST_BLINK_PERIOD   = 16'd500;
  localparam logic [CountWidth-1:0]   RST_TONE_FREQUENCY = 16'd2000;
  localparam logic [ColorWidth-1:0]   RST_ALARM_COLOR    = 24'hFF0000;
  localparam logic [1:0]              RST_OUTPUT_FLAGS   = 2'b11;

  // status colors at the dim status level
  localparam logic [ColorWidth-1:0] COLOR_STATUS_ROI   = 24'h000008;
  localparam logic [ColorWidth-1:0] COLOR_STATUS_GREEN = 24'h000800;
  localparam logic [ColorWidth-1:0] COLOR_OFF          = 24'h000000;
  localparam logic [CountWidth-1:0] COUNT_MAX          = 16'hFFFF;

  typedef struct packed {
    logic                          alarm_enable;
    logic signed [TempWidth-1:0]   high_threshold;
    logic signed [TempWidth-1:0]   low_threshold;
    logic [CountWidth-1:0]         hysteresis;
    logic [CountWidth-1:0]         blink_period;
    logic [CountWidth-1:0]         tone_frequency;
    logic [ColorWidth-1:0]         alarm_color;
    logic                          led_enable;
    logic                          buzzer_enable;
  } cfg_t;

  typedef struct packed {
    logic [CmdWidth-1:0]         command;
    logic signed [TempWidth-1:0] temperature;
    logic                        temperature_valid;
    logic                        roi_mode;
  } item_t;

  typedef struct packed {
    logic [ColorWidth-1:0] led_rgb;
    logic [CountWidth-1:0] buzzer_hz;
    logic                  alarm_on;
    logic                  high_latched;
    logic                  low_latched;
    logic                  alarm_changed;
  } result_t;

endpackage

### design/hysteresis_alarm_blinker.sv
// Hysteresis temperature alarm with blinking LED and buzzer drive.
//
// Input channel: in_valid_i / in_stall_o with command_i, temperature_i,
// temperature_valid_i and roi_mode_i. Commands are a temperature sample,
// a one-millisecond tick, and a sound test request.
// Output channel: out_valid_o / out_stall_i; exactly one result item per
// input item, showing LED color, buzzer frequency and latch state after it.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_index_i at the
// clock edge; write only while no item is in flight.
//
// An accepted item passes the input register, one pass of compare/update
// logic and the result register. Throughput: one item per cycle while no
// stall holds the result register, set by the single state-update pass.
// When out_stall_i is high the result register holds, the input register
// takes one more item, then in_stall_o rises until the result is taken.
// Reset clears the latches, blink and test state, LED and buzzer values,
// both valid flags, and loads the register defaults.
module hysteresis_alarm_blinker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hab_pkg::CmdWidth-1:0]       command_i,
  input  logic signed [hab_pkg::TempWidth-1:0] temperature_i,
  input  logic                               temperature_valid_i,
  input  logic                               roi_mode_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hab_pkg::ColorWidth-1:0]     led_rgb_o,
  output logic [hab_pkg::CountWidth-1:0]     buzzer_hz_o,
  output logic                               alarm_on_o,
  output logic                               high_latched_o,
  output logic                               low_latched_o,
  output logic                               alarm_changed_o,
  input  logic                               cfg_we_i,
  input  logic [hab_pkg::RegIdxWidth-1:0]    cfg_index_i,
  input  logic [hab_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);

  hab_pkg::cfg_t    cfg;
  hab_pkg::item_t   item_q;
  hab_pkg::result_t res_d, res_q;
  logic             s1_valid_q, out_valid_q;
  logic             advance, accept;

  hab_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hab_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  // item moves on when the result register is empty or being drained
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept)       s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance)           out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command           <= command_i;
      item_q.temperature       <= temperature_i;
      item_q.temperature_valid <= temperature_valid_i;
      item_q.roi_mode          <= roi_mode_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign led_rgb_o       = res_q.led_rgb;
  assign buzzer_hz_o     = res_q.buzzer_hz;
  assign alarm_on_o      = res_q.alarm_on;
  assign high_latched_o  = res_q.high_latched;
  assign low_latched_o   = res_q.low_latched;
  assign alarm_changed_o = res_q.alarm_changed;

  a_alarm_is_latch_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alarm_on_o == (high_latched_o || low_latched_o)))
    else $error("alarm_on does not match latch state");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without an item in the input register");

  a_changed_flips_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.alarm_changed |=> (res_q.alarm_on != $past(u_core.alarm_q)))
    else $error("alarm_changed set but alarm state kept");

endmodule

### design/hab_cfg_regs.sv
module hab_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hab_pkg::RegIdxWidth-1:0]      cfg_index_i,
  input  logic [hab_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  output hab_pkg::cfg_t                        cfg_o
);

  hab_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_enable   <= hab_pkg::RST_ALARM_ENABLE;
      cfg_q.high_threshold <= hab_pkg::RST_HIGH_THRESHOLD;
      cfg_q.low_threshold  <= hab_pkg::RST_LOW_THRESHOLD;
      cfg_q.hysteresis     <= hab_pkg::RST_HYSTERESIS;
      cfg_q.blink_period   <= hab_pkg::RST_BLINK_PERIOD;
      cfg_q.tone_frequency <= hab_pkg::RST_TONE_FREQUENCY;
      cfg_q.alarm_color    <= hab_pkg::RST_ALARM_COLOR;
      cfg_q.led_enable     <= hab_pkg::RST_OUTPUT_FLAGS[0];
      cfg_q.buzzer_enable  <= hab_pkg::RST_OUTPUT_FLAGS[1];
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hab_pkg::REG_ALARM_ENABLE:   cfg_q.alarm_enable   <= cfg_wdata_i[0];
        hab_pkg::REG_HIGH_THRESHOLD: cfg_q.high_threshold <= cfg_wdata_i[16:0];
        hab_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= cfg_wdata_i[16:0];
        hab_pkg::REG_HYSTERESIS:     cfg_q.hysteresis     <= cfg_wdata_i[15:0];
        hab_pkg::REG_BLINK_PERIOD:   cfg_q.blink_period   <= cfg_wdata_i[15:0];
        hab_pkg::REG_TONE_FREQUENCY: cfg_q.tone_frequency <= cfg_wdata_i[15:0];
        hab_pkg::REG_ALARM_COLOR:    cfg_q.alarm_color    <= cfg_wdata_i[23:0];
        hab_pkg::REG_OUTPUT_FLAGS: begin
          cfg_q.led_enable    <= cfg_wdata_i[0];
          cfg_q.buzzer_enable <= cfg_wdata_i[1];
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/hab_core.sv
module hab_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  hab_pkg::item_t   item_i,
  input  hab_pkg::cfg_t    cfg_i,
  output hab_pkg::result_t result_o
);

  logic                              high_q, high_d;
  logic                              low_q, low_d;
  logic                              alarm_q, alarm_d;
  logic                              phase_q, phase_d;
  logic                              test_q, test_d;
  logic [hab_pkg::CountWidth-1:0]    blink_cnt_q, blink_cnt_d;
  logic [hab_pkg::CountWidth-1:0]    test_cnt_q, test_cnt_d;
  logic [hab_pkg::ColorWidth-1:0]    led_q, led_d;
  logic [hab_pkg::CountWidth-1:0]    buzz_q, buzz_d;
  logic                              changed;

  // thresholds widened so the hysteresis margin cannot wrap
  logic signed [18:0] temp_w, high_w, low_w, high_rel_w, low_rel_w;
  logic               high_eval, low_eval, active;
  logic [hab_pkg::CountWidth-1:0] blink_bump, test_bump;
  logic [hab_pkg::ColorWidth-1:0] status_color;

  always_comb begin
    temp_w     = {{2{item_i.temperature[16]}}, item_i.temperature};
    high_w     = {{2{cfg_i.high_threshold[16]}}, cfg_i.high_threshold};
    low_w      = {{2{cfg_i.low_threshold[16]}}, cfg_i.low_threshold};
    high_rel_w = high_w - $signed({3'b000, cfg_i.hysteresis});
    low_rel_w  = low_w + $signed({3'b000, cfg_i.hysteresis});

    if (!high_q && temp_w >= high_w)          high_eval = 1'b1;
    else if (high_q && temp_w <= high_rel_w)  high_eval = 1'b0;
    else                                      high_eval = high_q;

    if (low_w < high_w) begin
      if (!low_q && temp_w <= low_w)          low_eval = 1'b1;
      else if (low_q && temp_w >= low_rel_w)  low_eval = 1'b0;
      else                                    low_eval = low_q;
    end else begin
      low_eval = 1'b0;
    end
    active = high_eval | low_eval;

    blink_bump = (blink_cnt_q != hab_pkg::COUNT_MAX) ? blink_cnt_q + 16'd1 : blink_cnt_q;
    test_bump  = (test_cnt_q != hab_pkg::COUNT_MAX) ? test_cnt_q + 16'd1 : test_cnt_q;

    if (!cfg_i.led_enable)     status_color = hab_pkg::COLOR_OFF;
    else if (item_i.roi_mode)  status_color = hab_pkg::COLOR_STATUS_ROI;
    else                       status_color = hab_pkg::COLOR_STATUS_GREEN;
  end

  always_comb begin
    high_d      = high_q;
    low_d       = low_q;
    alarm_d     = alarm_q;
    phase_d     = phase_q;
    test_d      = test_q;
    blink_cnt_d = blink_cnt_q;
    test_cnt_d  = test_cnt_q;
    led_d       = led_q;
    buzz_d      = buzz_q;
    changed     = 1'b0;

    case (item_i.command)
      hab_pkg::CMD_SAMPLE: begin
        if (cfg_i.alarm_enable && item_i.temperature_valid) begin
          high_d = high_eval;
          low_d  = low_eval;
          if (active != alarm_q) begin
            changed = 1'b1;
            alarm_d = active;
            if (active) begin
              test_d      = 1'b0;
              phase_d     = 1'b1;
              blink_cnt_d = '0;
              if (cfg_i.led_enable) led_d = cfg_i.alarm_color;
              buzz_d = cfg_i.buzzer_enable ? cfg_i.tone_frequency : '0;
            end else begin
              phase_d = 1'b0;
              buzz_d  = '0;
              led_d   = status_color;
            end
          end
        end
      end
      hab_pkg::CMD_TICK: begin
        if (alarm_q) begin
          if (blink_bump < cfg_i.blink_period) begin
            blink_cnt_d = blink_bump;
          end else begin
            blink_cnt_d = '0;
            phase_d     = !phase_q;
            if (cfg_i.led_enable) led_d = !phase_q ? cfg_i.alarm_color : hab_pkg::COLOR_OFF;
            buzz_d = (!phase_q && cfg_i.buzzer_enable) ? cfg_i.tone_frequency : '0;
          end
        end else if (test_q) begin
          test_cnt_d = test_bump;
          if (test_bump >= cfg_i.blink_period) begin
            test_d = 1'b0;
            buzz_d = '0;
            led_d  = status_color;
          end
        end else begin
          buzz_d = '0;
          led_d  = status_color;
        end
      end
      hab_pkg::CMD_TEST: begin
        // ignored while the alarm runs; restarts a running test
        if (!alarm_q) begin
          test_d     = 1'b1;
          test_cnt_d = '0;
          if (cfg_i.led_enable) led_d = cfg_i.alarm_color;
          buzz_d = cfg_i.tone_frequency;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q      <= 1'b0;
      low_q       <= 1'b0;
      alarm_q     <= 1'b0;
      phase_q     <= 1'b0;
      test_q      <= 1'b0;
      blink_cnt_q <= '0;
      test_cnt_q  <= '0;
      led_q       <= '0;
      buzz_q      <= '0;
    end else if (advance_i) begin
      high_q      <= high_d;
      low_q       <= low_d;
      alarm_q     <= alarm_d;
      phase_q     <= phase_d;
      test_q      <= test_d;
      blink_cnt_q <= blink_cnt_d;
      test_cnt_q  <= test_cnt_d;
      led_q       <= led_d;
      buzz_q      <= buzz_d;
    end
  end

  assign result_o.led_rgb       = led_d;
  assign result_o.buzzer_hz     = buzz_d;
  assign result_o.alarm_on      = alarm_d;
  assign result_o.high_latched  = high_d;
  assign result_o.low_latched   = low_d;
  assign result_o.alarm_changed = changed;

endmodule
